// ===== design/hfa_pkg.sv =====
`timescale 1ns / 1ps

package hfa_pkg;

	// field widths fixed by the item format
	localparam int unsigned AMT_W    = 16;
	localparam int unsigned HIDX_W   = 4;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned HCNT_W   = 5;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;
	// wide enough to hold any table size or index in the parameter range
	localparam int unsigned EXT_W    = 9;

	// fit policies
	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	// item kinds
	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_REQUEST = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_LOADED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

	// register indexes
	localparam logic REG_FIT_MODE   = 1'b0;
	localparam logic REG_HOLE_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scan_en;
		logic finish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic item_load;
		logic no_holes;
		logic scan_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== design/hfa_if.sv =====
`timescale 1ns / 1ps

interface hfa_item_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [hfa_pkg::HIDX_W-1:0]  hole_index;
	logic [hfa_pkg::AMT_W-1:0]   amount;

	modport source (output valid, output func, output hole_index, output amount, input ready);
	modport sink (input valid, input func, input hole_index, input amount, output ready);
endinterface

interface hfa_result_if;
	logic                          valid;
	logic                          ready;
	logic [hfa_pkg::STATUS_W-1:0]  status;
	logic [hfa_pkg::HIDX_W-1:0]    chosen_hole;
	logic [hfa_pkg::AMT_W-1:0]     remaining;

	modport source (output valid, output status, output chosen_hole, output remaining, input ready);
	modport sink (input valid, input status, input chosen_hole, input remaining, output ready);
endinterface

// ===== design/hfa_ctrl.sv =====
`timescale 1ns / 1ps

module hfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  hfa_pkg::dp_stat_t stat,
	output hfa_pkg::dp_cmd_t  cmd
);

	hfa_pkg::state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hfa_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			hfa_pkg::ST_IDLE: begin
				if (item_valid) begin
					if (stat.item_load || stat.no_holes) begin
						state_nxt = hfa_pkg::ST_FINISH;
					end else begin
						state_nxt = hfa_pkg::ST_SCAN;
					end
				end
			end
			hfa_pkg::ST_SCAN: begin
				if (stat.scan_done) begin
					state_nxt = hfa_pkg::ST_FINISH;
				end
			end
			hfa_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					state_nxt = hfa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = hfa_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		item_ready  = 1'b0;
		cmd.accept  = 1'b0;
		cmd.scan_en = 1'b0;
		cmd.finish  = 1'b0;
		case (state_q)
			hfa_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				cmd.accept = item_valid;
			end
			hfa_pkg::ST_SCAN: begin
				cmd.scan_en = 1'b1;
			end
			hfa_pkg::ST_FINISH: begin
				cmd.finish = stat.out_free;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	// an accepted word always leaves idle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (state_q != hfa_pkg::ST_IDLE))
		else $error("accepted word did not start work");

	// scan ends only into finish
	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hfa_pkg::ST_SCAN) |=>
		(state_q == hfa_pkg::ST_SCAN || state_q == hfa_pkg::ST_FINISH))
		else $error("scan left to wrong state");

	// a result is only loaded when the output register can take it
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> stat.out_free)
		else $error("result overwrote pending output");

endmodule

// ===== design/hfa_dp.sv =====
`timescale 1ns / 1ps

module hfa_dp #(
	parameter int unsigned MAX_HOLES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hfa_pkg::dp_cmd_t               cmd,
	output hfa_pkg::dp_stat_t              stat,
	input  logic [hfa_pkg::MODE_W-1:0]     fit_mode,
	input  logic [hfa_pkg::HCNT_W-1:0]     hole_count,
	hfa_item_if.sink                       item,
	hfa_result_if.source                   result
);

	localparam int unsigned IW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
	localparam int unsigned CW = $clog2(MAX_HOLES + 1);
	localparam int unsigned XW = hfa_pkg::EXT_W;

	// hole table and its valid bits
	logic [hfa_pkg::AMT_W-1:0] mem_q [MAX_HOLES];
	logic [MAX_HOLES-1:0]      vld_q;

	// captured item
	logic                        func_q;
	logic [hfa_pkg::HIDX_W-1:0]  hidx_q;
	logic [hfa_pkg::AMT_W-1:0]   amt_q;

	// scan state
	logic [CW-1:0]               cnt_q;
	logic                        rd_vld_s1;
	logic                        rd_hit_s1;
	logic [IW-1:0]               rd_idx_s1;
	logic [hfa_pkg::AMT_W-1:0]   rd_data_s1;
	logic                        found_q;
	logic [IW-1:0]               best_idx_q;
	logic [hfa_pkg::AMT_W-1:0]   best_size_q;

	// output register
	logic                          out_vld_q;
	logic [hfa_pkg::STATUS_W-1:0]  out_status_q;
	logic [hfa_pkg::HIDX_W-1:0]    out_hole_q;
	logic [hfa_pkg::AMT_W-1:0]     out_rem_q;

	logic [XW-1:0]               n_ext;
	logic [CW-1:0]               n_use;
	logic [XW-1:0]               hidx_ext;
	logic [XW-1:0]               best_ext;
	logic                        load_in_table;
	logic [IW-1:0]               load_addr;
	logic [IW-1:0]               rd_addr;
	logic                        issue;
	logic [hfa_pkg::AMT_W-1:0]   cand;
	logic                        fits;
	logic                        is_best;
	logic                        is_worst;
	logic                        take;
	logic [hfa_pkg::AMT_W-1:0]   left;
	logic                        wr_en;
	logic [IW-1:0]               wr_addr;
	logic [hfa_pkg::AMT_W-1:0]   wr_data;

	// holes in use, clamped to the table size
	always_comb begin
		if (XW'(hole_count) > XW'(MAX_HOLES)) begin
			n_ext = XW'(MAX_HOLES);
		end else begin
			n_ext = XW'(hole_count);
		end
		n_use = n_ext[CW-1:0];
	end

	assign hidx_ext      = XW'(hidx_q);
	assign best_ext      = XW'(best_idx_q);
	assign load_in_table = (hidx_ext < XW'(MAX_HOLES));
	assign load_addr     = hidx_ext[IW-1:0];
	assign rd_addr       = cnt_q[IW-1:0];
	assign issue         = cmd.scan_en && (cnt_q < n_use);

	// candidate compare against the running choice
	assign cand     = rd_hit_s1 ? rd_data_s1 : '0;
	assign fits     = (cand >= amt_q);
	assign is_best  = (fit_mode == hfa_pkg::MODE_BEST);
	assign is_worst = (fit_mode == hfa_pkg::MODE_WORST);
	assign take     = rd_vld_s1 && fits && (!found_q ||
		(is_best && (cand < best_size_q)) || (is_worst && (cand > best_size_q)));
	assign left     = best_size_q - amt_q;

	// status to controller
	assign stat.item_load = (item.func == hfa_pkg::FUNC_LOAD);
	assign stat.no_holes  = (n_use == '0);
	assign stat.scan_done = (cnt_q >= n_use) && !rd_vld_s1;
	assign stat.out_free  = !out_vld_q || result.ready;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= item.func;
			hidx_q <= item.hole_index;
			amt_q  <= item.amount;
		end
	end

	// scan counter, read issue flag and found flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.accept) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// table read, one entry a cycle, and running choice update
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem_q[rd_addr];
			rd_hit_s1  <= vld_q[rd_addr];
			rd_idx_s1  <= rd_addr;
		end
		if (take) begin
			best_idx_q  <= rd_idx_s1;
			best_size_q <= cand;
		end
	end

	// table write: a load or the shrink of the granted hole
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = load_addr;
		wr_data = amt_q;
		if (cmd.finish) begin
			if (func_q == hfa_pkg::FUNC_LOAD) begin
				wr_en = load_in_table;
			end else begin
				wr_en   = found_q;
				wr_addr = best_idx_q;
				wr_data = left;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.finish) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (func_q == hfa_pkg::FUNC_LOAD) begin
				out_status_q <= hfa_pkg::ST_LOADED;
				out_hole_q   <= hidx_q;
				out_rem_q    <= load_in_table ? amt_q : '0;
			end else if (found_q) begin
				out_status_q <= hfa_pkg::ST_GRANTED;
				out_hole_q   <= best_ext[hfa_pkg::HIDX_W-1:0];
				out_rem_q    <= left;
			end else begin
				out_status_q <= hfa_pkg::ST_REFUSED;
				out_hole_q   <= '0;
				out_rem_q    <= '0;
			end
		end
	end

	assign item.ready         = cmd.accept;
	assign result.valid       = out_vld_q;
	assign result.status      = out_status_q;
	assign result.chosen_hole = out_hole_q;
	assign result.remaining   = out_rem_q;

	// the running choice always fits the request
	a_choice_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && !cmd.accept) |-> (best_size_q >= amt_q))
		else $error("chosen hole smaller than request");

	// a read result only follows an issued read
	a_read_issued: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(cmd.scan_en))
		else $error("read data without issue");

	// the counter never passes the holes in use while scanning
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_en |-> (cnt_q <= n_use))
		else $error("scan ran past holes in use");

endmodule

// ===== design/hole_fit_allocator.sv =====
`timescale 1ns / 1ps

// Hole-table allocator. Words arrive on the item channel (valid/ready): a load
// word (func 0) writes a hole size, a request word (func 1) takes amount from
// a hole chosen by fit_mode (first, best or worst fit, ties to the lowest
// index) among the lowest hole_count holes. Each word yields one word on the
// result channel: loaded, granted with the hole and its remaining size, or
// refused. fit_mode and hole_count are written over the APB port; the user
// must write them only while idle, as the block itself does not enforce it.
// A load, or a request with no holes in use, goes from accept straight to
// the finish state; a request first scans the holes in use, reading the hole
// table one entry per cycle. One word is worked on at a time; the next word
// is accepted as soon as the previous result sits in the output register,
// even while the receiver stalls it. A stalled result holds; a finished word
// waits in the controller until the output register frees. Reset clears both
// registers, the table (every hole reads zero) and all pending work; no
// clearing pass is needed.
module hole_fit_allocator #(
	parameter int unsigned MAX_HOLES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	hfa_item_if.sink                      item,
	hfa_result_if.source                  result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hfa_pkg::PADDR_W-1:0]   paddr,
	input  logic [hfa_pkg::PDATA_W-1:0]   pwdata,
	output logic [hfa_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [hfa_pkg::MODE_W-1:0]  fit_mode_q;
	logic [hfa_pkg::HCNT_W-1:0]  hole_count_q;
	logic                        reg_wr;
	logic                        reg_idx;
	hfa_pkg::dp_cmd_t            cmd;
	hfa_pkg::dp_stat_t           stat;
	logic                        ctrl_ready;

	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[2];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q   <= hfa_pkg::MODE_FIRST;
			hole_count_q <= '0;
		end else if (reg_wr) begin
			if (reg_idx == hfa_pkg::REG_FIT_MODE) begin
				fit_mode_q <= pwdata[hfa_pkg::MODE_W-1:0];
			end else begin
				hole_count_q <= pwdata[hfa_pkg::HCNT_W-1:0];
			end
		end
	end

	// register read back
	always_comb begin
		if (reg_idx == hfa_pkg::REG_FIT_MODE) begin
			prdata = hfa_pkg::PDATA_W'(fit_mode_q);
		end else begin
			prdata = hfa_pkg::PDATA_W'(hole_count_q);
		end
	end

	hfa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (ctrl_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	hfa_dp #(
		.MAX_HOLES (MAX_HOLES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.fit_mode   (fit_mode_q),
		.hole_count (hole_count_q),
		.item       (item),
		.result     (result)
	);

	// controller ready and datapath accept must agree
	a_ready_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && ctrl_ready) |-> cmd.accept)
		else $error("accept not issued for ready word");

	a_ready_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> ctrl_ready)
		else $error("accept without ready");

	a_finish_idle_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> ctrl_ready)
		else $error("not idle after result load");

endmodule

// ===== dv/tb_hole_fit_allocator.sv =====
`timescale 1ns / 1ps

module tb_hole_fit_allocator;

	localparam int unsigned TABLE_DEPTH = 16;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned SETTLE_CYCLES = 25;
	localparam int unsigned NUM_PHASES = 12;
	localparam int unsigned PHASE_WORDS = 160;
	// mode code with no defined policy, behaves as first fit
	localparam logic [hfa_pkg::MODE_W-1:0] MODE_UNDEF = 2'd3;

	typedef struct packed {
		logic                       func;
		logic [hfa_pkg::HIDX_W-1:0] hole_index;
		logic [hfa_pkg::AMT_W-1:0]  amount;
		logic                       drain_first;
	} alloc_word_t;

	typedef struct packed {
		logic [hfa_pkg::STATUS_W-1:0] status;
		logic [hfa_pkg::HIDX_W-1:0]   chosen_hole;
		logic [hfa_pkg::AMT_W-1:0]    remaining;
	} result_word_t;

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [hfa_pkg::PADDR_W-1:0]  paddr;
	logic [hfa_pkg::PDATA_W-1:0]  pwdata;
	logic [hfa_pkg::PDATA_W-1:0]  prdata;
	logic                         pready;

	hfa_item_if   item_ch ();
	hfa_result_if result_ch ();

	hole_fit_allocator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the block state
	logic [hfa_pkg::AMT_W-1:0]  hole_table [TABLE_DEPTH];
	logic [hfa_pkg::MODE_W-1:0] mode_copy;
	logic [hfa_pkg::HCNT_W-1:0] count_copy;

	alloc_word_t  pending_words [$];
	result_word_t expected_results [$];

	int unsigned mismatches;
	int unsigned cycle_count;
	int unsigned n_loaded;
	int unsigned n_granted;
	int unsigned n_refused;
	int unsigned n_settings;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// load or allocate against the shadow table, return the result word
	function automatic result_word_t allocate_or_load(alloc_word_t w);
		result_word_t r;
		int unsigned  in_use;
		int unsigned  i;
		int unsigned  pick;
		bit           found;
		logic [hfa_pkg::AMT_W-1:0] pick_amt;
		r = '0;
		if (w.func == hfa_pkg::FUNC_LOAD) begin
			hole_table[w.hole_index] = w.amount;
			r.status = hfa_pkg::ST_LOADED;
			r.chosen_hole = w.hole_index;
			r.remaining = w.amount;
			n_loaded++;
		end else begin
			in_use = (count_copy > TABLE_DEPTH) ? TABLE_DEPTH : count_copy;
			found = 1'b0;
			pick = 0;
			pick_amt = '0;
			for (i = 0; i < in_use; i++) begin
				if (hole_table[i] >= w.amount) begin
					if (!found) begin
						found = 1'b1;
						pick = i;
						pick_amt = hole_table[i];
					end else if (mode_copy == hfa_pkg::MODE_BEST &&
							hole_table[i] < pick_amt) begin
						pick = i;
						pick_amt = hole_table[i];
					end else if (mode_copy == hfa_pkg::MODE_WORST &&
							hole_table[i] > pick_amt) begin
						pick = i;
						pick_amt = hole_table[i];
					end
				end
			end
			if (found) begin
				hole_table[pick] = pick_amt - w.amount;
				r.status = hfa_pkg::ST_GRANTED;
				r.chosen_hole = pick[hfa_pkg::HIDX_W-1:0];
				r.remaining = hole_table[pick];
				n_granted++;
			end else begin
				r.status = hfa_pkg::ST_REFUSED;
				n_refused++;
			end
		end
		return r;
	endfunction

	function automatic logic [hfa_pkg::AMT_W-1:0] pick_size();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return hfa_pkg::AMT_W'($urandom_range(0, 255));
			4: return hfa_pkg::AMT_W'($urandom_range(256, 4095));
			default: return hfa_pkg::AMT_W'($urandom);
		endcase
	endfunction

	function automatic logic [hfa_pkg::AMT_W-1:0] pick_request();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3, 4: return hfa_pkg::AMT_W'($urandom_range(1, 64));
			5: return hfa_pkg::AMT_W'($urandom_range(65, 1024));
			default: return hfa_pkg::AMT_W'($urandom);
		endcase
	endfunction

	task automatic push_word(input logic func, input int unsigned idx,
			input logic [hfa_pkg::AMT_W-1:0] amt, input logic drain);
		alloc_word_t w;
		w.func = func;
		w.hole_index = idx[hfa_pkg::HIDX_W-1:0];
		w.amount = amt;
		w.drain_first = drain;
		pending_words.push_back(w);
	endtask

	// apb write: setup then access, register taken at the access edge
	task automatic write_reg(input logic reg_sel,
			input logic [hfa_pkg::PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == hfa_pkg::REG_FIT_MODE)
			mode_copy = value[hfa_pkg::MODE_W-1:0];
		else
			count_copy = value[hfa_pkg::HCNT_W-1:0];
	endtask

	task automatic set_policy(input int unsigned mode, input int unsigned count);
		write_reg(hfa_pkg::REG_FIT_MODE, hfa_pkg::PDATA_W'(mode));
		write_reg(hfa_pkg::REG_HOLE_COUNT, hfa_pkg::PDATA_W'(count));
		n_settings++;
		@(negedge clk);
	endtask

	// block is idle once every word is sent and every result has come back
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_words.size() != 0 || expected_results.size() != 0 || item_ch.valid);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// item driver: bursts with random gaps, holds a word until accepted
	alloc_word_t drv_word;
	bit          drv_busy;
	int unsigned gap_left;
	int unsigned burst_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.func <= hfa_pkg::FUNC_LOAD;
			item_ch.hole_index <= '0;
			item_ch.amount <= '0;
			drv_busy = 1'b0;
			drv_word = '0;
			gap_left = 0;
			burst_left = 1;
		end else begin
			if (drv_busy && item_ch.ready) begin
				expected_results.push_back(allocate_or_load(drv_word));
				drv_busy = 1'b0;
			end
			if (!drv_busy) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_words.size() != 0 &&
						!(pending_words[0].drain_first && expected_results.size() != 0)) begin
					drv_word = pending_words.pop_front();
					drv_busy = 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						case ($urandom_range(0, 5))
							0: gap_left = $urandom_range(20, 40);
							1, 2: gap_left = 0;
							default: gap_left = $urandom_range(1, 6);
						endcase
						burst_left = $urandom_range(1, 24);
					end
				end
			end
			item_ch.valid <= drv_busy;
			item_ch.func <= drv_word.func;
			item_ch.hole_index <= drv_word.hole_index;
			item_ch.amount <= drv_word.amount;
		end
	end

	// result monitor and receiver stall pattern
	logic [15:0] stall_bits;
	int unsigned stall_phase;
	result_word_t got;
	result_word_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_bits = 16'hFFFF;
			stall_phase = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got.status = result_ch.status;
				got.chosen_hole = result_ch.chosen_hole;
				got.remaining = result_ch.remaining;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: status %0d hole %0d remaining %0d",
							got.status, got.chosen_hole, got.remaining);
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status || got.chosen_hole !== want.chosen_hole ||
							got.remaining !== want.remaining) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected status %0d hole %0d remaining %0d",
								want.status, want.chosen_hole, want.remaining);
							$display("          got status %0d hole %0d remaining %0d",
								got.status, got.chosen_hole, got.remaining);
						end
					end
				end
			end
			// reload the stall pattern now and then, sometimes with no stalls at all
			stall_phase++;
			if (stall_phase % 64 == 0) begin
				case ($urandom_range(0, 3))
					0: stall_bits = 16'hFFFF;
					1: stall_bits = 16'($urandom) | 16'($urandom);
					2: stall_bits = 16'h00FF;
					default: stall_bits = 16'($urandom);
				endcase
				if (stall_bits == 16'h0000)
					stall_bits = 16'h0001;
			end else begin
				stall_bits = {stall_bits[0], stall_bits[15:1]};
			end
			result_ch.ready <= stall_bits[0];
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// reset, directed words, then random phases
	initial begin
		logic [hfa_pkg::MODE_W-1:0] phase_modes [NUM_PHASES];
		int unsigned phase_counts [NUM_PHASES];
		int unsigned p;
		int unsigned k;
		int unsigned in_use;
		int unsigned drain_at;

		phase_modes = '{hfa_pkg::MODE_FIRST, hfa_pkg::MODE_BEST, hfa_pkg::MODE_WORST,
			MODE_UNDEF, hfa_pkg::MODE_BEST, hfa_pkg::MODE_WORST, hfa_pkg::MODE_FIRST,
			hfa_pkg::MODE_BEST, hfa_pkg::MODE_WORST, hfa_pkg::MODE_FIRST,
			hfa_pkg::MODE_BEST, hfa_pkg::MODE_WORST};
		phase_counts = '{16, 16, 16, 31, 1, 0, 17, 8, 0, 16, 0, 16};
		phase_counts[8] = $urandom_range(2, 15);
		phase_counts[10] = $urandom_range(0, 31);

		mismatches = 0;
		n_loaded = 0;
		n_granted = 0;
		n_refused = 0;
		n_settings = 0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			hole_table[i] = '0;
		mode_copy = hfa_pkg::MODE_FIRST;
		count_copy = '0;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.func = hfa_pkg::FUNC_LOAD;
		item_ch.hole_index = '0;
		item_ch.amount = '0;
		result_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// no holes in use, loads beyond the count
		set_policy(hfa_pkg::MODE_FIRST, 0);
		push_word(hfa_pkg::FUNC_REQUEST, 0, '0, 1'b0);
		push_word(hfa_pkg::FUNC_LOAD, 0, 16'd100, 1'b0);
		push_word(hfa_pkg::FUNC_LOAD, 15, 16'hFFFF, 1'b0);
		push_word(hfa_pkg::FUNC_LOAD, 3, 16'd50, 1'b0);
		push_word(hfa_pkg::FUNC_REQUEST, 9, 16'd10, 1'b0);
		wait_idle();

		// undefined mode acts as first fit, oversize count clamps to the table
		set_policy(MODE_UNDEF, 20);
		push_word(hfa_pkg::FUNC_REQUEST, 0, 16'hFFFF, 1'b0);
		push_word(hfa_pkg::FUNC_REQUEST, 0, '0, 1'b0);
		push_word(hfa_pkg::FUNC_LOAD, 7, 16'hFFFF, 1'b0);
		wait_idle();

		// best fit, zero request picks an empty hole
		set_policy(hfa_pkg::MODE_BEST, 16);
		push_word(hfa_pkg::FUNC_REQUEST, 0, 16'd40, 1'b0);
		push_word(hfa_pkg::FUNC_REQUEST, 0, 16'd5, 1'b0);
		push_word(hfa_pkg::FUNC_REQUEST, 0, '0, 1'b0);
		wait_idle();

		// worst fit, tie goes to the lower index
		set_policy(hfa_pkg::MODE_WORST, 8);
		push_word(hfa_pkg::FUNC_REQUEST, 0, 16'd1, 1'b0);
		push_word(hfa_pkg::FUNC_REQUEST, 0, 16'hFFFF, 1'b0);
		push_word(hfa_pkg::FUNC_LOAD, 5, 16'hFFFE, 1'b0);
		push_word(hfa_pkg::FUNC_REQUEST, 0, 16'hFFFE, 1'b0);
		push_word(hfa_pkg::FUNC_LOAD, 10, 16'h5555, 1'b0);
		push_word(hfa_pkg::FUNC_LOAD, 6, 16'hAAAA, 1'b0);
		wait_idle();

		// random phases: fill the holes in use, then mixed traffic
		for (p = 0; p < NUM_PHASES; p++) begin
			set_policy(phase_modes[p], phase_counts[p]);
			in_use = (phase_counts[p] > TABLE_DEPTH) ? TABLE_DEPTH : phase_counts[p];
			for (k = 0; k < in_use; k++)
				push_word(hfa_pkg::FUNC_LOAD, k, pick_size(), 1'b0);
			drain_at = $urandom_range(20, 120);
			for (k = 0; k < PHASE_WORDS - in_use; k++) begin
				if ($urandom_range(0, 3) == 0)
					push_word(hfa_pkg::FUNC_LOAD, $urandom_range(0, 15), pick_size(),
						k == drain_at);
				else
					push_word(hfa_pkg::FUNC_REQUEST, $urandom_range(0, 15), pick_request(),
						k == drain_at);
			end
			wait_idle();
		end

		if (expected_results.size() != 0) begin
			mismatches++;
			$display("%0d result words never arrived", expected_results.size());
		end
		$display("covered %0d loads, %0d grants and %0d refusals", n_loaded, n_granted,
			n_refused);
		$display("across %0d register settings, all four mode codes, hole counts 0 to 31",
			n_settings);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/hfa_pkg.sv
design/hfa_if.sv
design/hfa_ctrl.sv
design/hfa_dp.sv
design/hole_fit_allocator.sv
dv/tb_hole_fit_allocator.sv
